FILE: hdl/lir_pkg.sv
// Package with constants and types for the linear interpolation resampler.
package lir_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned IN_RATE_W = 14;
    localparam int unsigned OUT_RATE_W = 15;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [IN_RATE_W-1:0] IN_RATE_LO = 14'd8000;
    localparam logic [IN_RATE_W-1:0] IN_RATE_HI = 14'd16000;
    localparam logic [IN_RATE_W-1:0] IN_RATE_RST = 14'd10000;
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_LO = 15'd8000;
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_HI = 15'd22000;
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_RST = 15'd22000;

    localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;

    localparam logic CFG_IDX_IN_RATE = 1'b0;
    localparam logic CFG_IDX_OUT_RATE = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL0  = 6'b000010,
        ST_MUL1  = 6'b000100,
        ST_SETUP = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

endpackage

FILE: hdl/linear_interp_resampler.sv
// Linear interpolation sample rate converter with a shared multiplier and serial divider.
//
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_ready   i_sample
//  output    out        o_valid / i_ready   o_out_sample, o_last
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A pass-through request goes straight to the emit state; the first sample of a stream is only stored.
// Each interpolated result passes through the multiply states ST_MUL0 and ST_MUL1, the setup state,
// sixteen steps of the restoring divider and the emit state, which loads the output register.
// A request yields at most three results.
// Reset is synchronous, restores the default rates, clears the stream state and empties the output.
// While the output register is full and not taken, the sequencer waits before loading.
module linear_interp_resampler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [lir_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0]   o_out_sample,
    output logic                                  o_last
);
    import lir_pkg::*;

    t_state r_state, n_state;

    logic [IN_RATE_W-1:0]  r_in_rate;
    logic [OUT_RATE_W-1:0] r_out_rate;
    logic                  r_have_prev;
    logic signed [15:0]    r_prev;
    logic [14:0]           r_phase;

    logic signed [15:0]    r_cur;
    logic                  r_pass;
    logic [16:0]           r_ph;
    logic [1:0]            r_n;
    logic signed [31:0]    r_acc;
    logic [15:0]           r_rem;
    logic [15:0]           r_dq;
    logic                  r_neg;
    logic [3:0]            r_cnt;

    logic                  r_out_valid;
    logic signed [15:0]    r_out_sample;
    logic                  r_out_last;

    logic [IN_RATE_W-1:0]  w_ri;
    logic [OUT_RATE_W-1:0] w_ro;
    logic signed [15:0]    w_mul_a;
    logic signed [15:0]    w_mul_b;
    logic signed [31:0]    w_prod;
    logic [31:0]           w_mag;
    logic [31:0]           w_dend;
    logic [15:0]           w_div;
    logic [16:0]           w_trial;
    logic                  w_ge;
    logic [16:0]           w_diff;
    logic signed [15:0]    w_y;
    logic [16:0]           w_ph_next;
    logic                  w_more;
    logic                  w_last;
    logic                  w_slot;
    logic                  w_accept;
    logic [14:0]           w_phase_end;

    always_comb begin
        if (r_in_rate < IN_RATE_LO) begin
            w_ri = IN_RATE_LO;
        end else if (r_in_rate > IN_RATE_HI) begin
            w_ri = IN_RATE_HI;
        end else begin
            w_ri = r_in_rate;
        end
        if (r_out_rate < OUT_RATE_LO) begin
            w_ro = OUT_RATE_LO;
        end else if (r_out_rate > OUT_RATE_HI) begin
            w_ro = OUT_RATE_HI;
        end else begin
            w_ro = r_out_rate;
        end
    end

    // The numerator is prev * (ro - ph) + cur * ph, built by the shared multiplier in ST_MUL0 and ST_MUL1.
    always_comb begin
        if (r_state == ST_MUL0) begin
            w_mul_a = r_prev;
            w_mul_b = $signed({1'b0, w_ro - r_ph[14:0]});
        end else begin
            w_mul_a = r_cur;
            w_mul_b = $signed({1'b0, r_ph[14:0]});
        end
    end
    assign w_prod = w_mul_a * w_mul_b;

    assign w_mag   = r_acc[31] ? 32'(-r_acc) : 32'(r_acc);
    assign w_dend  = {w_mag[30:0], 1'b0} + {17'd0, w_ro};
    assign w_div   = {w_ro, 1'b0};
    assign w_trial = {r_rem, r_dq[15]};
    assign w_ge    = w_trial >= {1'b0, w_div};
    assign w_diff  = w_trial - {1'b0, w_div};

    always_comb begin
        if (!r_neg) begin
            w_y = r_dq[15] ? S16_MAX : $signed(r_dq);
        end else if (r_dq > 16'h8000) begin
            w_y = S16_MIN;
        end else begin
            w_y = $signed(16'(-{1'b0, r_dq}));
        end
    end

    assign w_ph_next = r_ph + {3'd0, w_ri};
    assign w_more    = (w_ph_next < {2'd0, w_ro}) && (r_n != 2'd2);
    assign w_last    = r_pass || !w_more;
    assign w_slot    = !r_out_valid || i_ready;
    assign o_ready   = (r_state == ST_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_phase_end = (w_ph_next >= {2'd0, w_ro}) ? 15'(w_ph_next - {2'd0, w_ro}) : 15'd0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_ri == w_ro) begin
                        n_state = ST_EMIT;
                    end else if (r_have_prev && (r_phase < w_ro)) begin
                        n_state = ST_MUL0;
                    end
                end
            end
            ST_MUL0:  n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_SETUP;
            ST_SETUP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == 4'd15) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot) begin
                    n_state = w_last ? ST_IDLE : ST_MUL0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_rate   <= IN_RATE_RST;
            r_out_rate  <= OUT_RATE_RST;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_IN_RATE) begin
                    r_in_rate <= i_cfg_data[IN_RATE_W-1:0];
                end else begin
                    r_out_rate <= i_cfg_data[OUT_RATE_W-1:0];
                end
            end
            if (w_accept && (w_ri != w_ro)) begin
                if (!r_have_prev) begin
                    r_have_prev <= 1'b1;
                    r_prev      <= i_sample;
                end else if (r_phase >= w_ro) begin
                    r_phase <= r_phase - w_ro;
                    r_prev  <= i_sample;
                end
            end
            if ((r_state == ST_EMIT) && w_slot) begin
                r_out_valid <= 1'b1;
                if (w_last && !r_pass) begin
                    r_phase <= w_phase_end;
                    r_prev  <= r_cur;
                end
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur  <= i_sample;
            r_pass <= (w_ri == w_ro);
            r_ph   <= {2'd0, r_phase};
            r_n    <= 2'd0;
        end
        unique case (r_state)
            ST_MUL0: r_acc <= w_prod;
            ST_MUL1: r_acc <= r_acc + w_prod;
            ST_SETUP: begin
                r_neg <= r_acc[31];
                r_rem <= w_dend[31:16];
                r_dq  <= w_dend[15:0];
                r_cnt <= 4'd0;
            end
            ST_DIV: begin
                r_rem <= w_ge ? w_diff[15:0] : w_trial[15:0];
                r_dq  <= {r_dq[14:0], w_ge};
                r_cnt <= r_cnt + 4'd1;
            end
            ST_EMIT: begin
                if (w_slot) begin
                    r_out_sample <= r_pass ? r_cur : w_y;
                    r_out_last   <= w_last;
                    r_ph         <= w_ph_next;
                    r_n          <= r_n + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_last       = r_out_last;

endmodule
